@@ design/lru_block_buffer_cache_defines.svh @@
// Assertion macros used by the buffer cache controller.
`ifndef LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_DEFINES_SVH
// Property checked on every rising clock edge outside reset.
`define LBC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Signal is never high while another one is high.
`define LBC_NEVER_BOTH(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);
`endif

@@ design/lbc_pkg.sv @@
// Types and codes shared by the buffer cache modules.
package lbc_pkg;
	localparam int CMD_W = 3;
	localparam int IDX_W = 4;
	localparam int BLK_W = 24;
	localparam int STS_W = 2;
	localparam int OP_W = 2;

	localparam logic [CMD_W-1:0] CMD_GET = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE_NOW = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE_DELAYED = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd5;

	localparam logic [STS_W-1:0] STS_OK = 2'd0;
	localparam logic [STS_W-1:0] STS_NO_FREE = 2'd1;
	localparam logic [STS_W-1:0] STS_BUSY = 2'd2;

	localparam logic [OP_W-1:0] OP_NONE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [BLK_W-1:0] block_number;
		logic [IDX_W-1:0] buffer_index;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [IDX_W-1:0] result_buffer;
		logic             hit;
		logic [OP_W-1:0]  disk_op;
		logic [BLK_W-1:0] disk_block;
		logic             last;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // capture request, start lookup
		logic execute;  // apply single-result command
		logic evict;    // emit victim write-back
		logic scan;     // flush: test current index
		logic emit;     // capture result into output register
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_evict; // miss victim is valid and dirty
		logic is_flush;
		logic scan_dirty; // flush: current index dirty
		logic more_dirty; // flush: a dirty buffer lies past the current index
	} sts_t;
endpackage

@@ design/lbc_stream_if.sv @@
// Valid/ready channel carrying a payload of a given type.
interface lbc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/lbc_datapath.sv @@
// Buffer table, LRU free queue, lookup and result formation.
module lbc_datapath #(
	parameter int BUFFERS = 16,
	parameter int BLOCK_BITS = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lbc_pkg::req_t  req,
	input  lbc_pkg::cmd_t  cmd,
	output lbc_pkg::sts_t  sts,
	output lbc_pkg::rsp_t  rsp
);
	import lbc_pkg::*;
	localparam int BW = $clog2(BUFFERS);
	localparam int CW = $clog2(BUFFERS + 1);

	logic [BLOCK_BITS-1:0] tag_q [BUFFERS];
	logic [BUFFERS-1:0] valid_q, done_q, dirty_q, held_q;
	logic [BW-1:0] order_q [BUFFERS];
	logic [CW-1:0] fcount_q;

	req_t req_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic found_q;
	logic [BW-1:0] fbuf_q;
	logic [BW-1:0] scan_q;
	rsp_t pend_q, rsp_q;

	// Lookup compare, registered at load.
	logic [BLOCK_BITS-1:0] blk_in;
	logic found_c;
	logic [BW-1:0] fbuf_c;
	assign blk_in = BLOCK_BITS'(req.block_number);
	always_comb begin
		found_c = 1'b0;
		fbuf_c = '0;
		for (int i = BUFFERS - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == blk_in) begin
				found_c = 1'b1;
				fbuf_c = BW'(i);
			end
		end
	end

	logic idx_ok;
	logic [BW-1:0] idx;
	assign idx_ok = 32'(req_q.buffer_index) < BUFFERS;
	assign idx = BW'(req_q.buffer_index);

	logic is_get, miss_ok;
	logic [BW-1:0] victim, tgt;
	assign is_get = req_q.command == CMD_GET || req_q.command == CMD_READ;
	assign victim = order_q[0];
	assign miss_ok = fcount_q != '0;
	assign tgt = found_q ? fbuf_q : victim;

	// Dirty buffers above the scan index decide which write ends the flush.
	logic more_c;
	always_comb begin
		more_c = 1'b0;
		for (int i = 0; i < BUFFERS; i++)
			if (32'(i) > 32'(scan_q) && dirty_q[i]) more_c = 1'b1;
	end

	assign sts.need_evict = is_get && !found_q && miss_ok && valid_q[victim] && dirty_q[victim];
	assign sts.is_flush = req_q.command == CMD_FLUSH;
	assign sts.scan_dirty = dirty_q[scan_q];
	assign sts.more_dirty = more_c;
	assign rsp = rsp_q;

	// Queue position of a buffer.
	logic [BW-1:0] pos;
	logic [BW-1:0] rm;
	logic do_rm, do_app;
	logic [BW-1:0] app;
	always_comb begin
		rm = found_q ? fbuf_q : victim;
		pos = '0;
		for (int i = 0; i < BUFFERS; i++)
			if (32'(i) < 32'(fcount_q) && order_q[i] == rm) pos = BW'(i);
	end

	// Victim write-back and flush scan results.
	rsp_t ev_r, sc_r;
	always_comb begin
		ev_r = '0;
		ev_r.result_buffer = IDX_W'(victim);
		ev_r.disk_op = OP_WRITE;
		ev_r.disk_block = BLK_W'(tag_q[victim]);
		sc_r = '0;
		sc_r.last = 1'b1;
		if (dirty_q[scan_q]) begin
			sc_r.result_buffer = IDX_W'(scan_q);
			sc_r.disk_op = OP_WRITE;
			sc_r.disk_block = BLK_W'(tag_q[scan_q]);
			sc_r.last = !more_c;
		end
	end

	// Single-result command evaluation.
	rsp_t one;
	always_comb begin
		one = '0;
		one.last = 1'b1;
		do_rm = 1'b0;
		do_app = 1'b0;
		app = idx;
		if (is_get) begin
			if (found_q && held_q[fbuf_q]) begin
				one.status = STS_BUSY;
				one.result_buffer = IDX_W'(fbuf_q);
				one.hit = 1'b1;
			end else if (!found_q && !miss_ok) begin
				one.status = STS_NO_FREE;
			end else begin
				do_rm = 1'b1;
				one.result_buffer = IDX_W'(tgt);
				one.hit = found_q;
				if (req_q.command == CMD_READ &&
						(!found_q || (!done_q[tgt] && !dirty_q[tgt]))) begin
					one.disk_op = OP_READ;
					one.disk_block = BLK_W'(blk_q);
				end
			end
		end else if (req_q.command == CMD_RELEASE || req_q.command == CMD_WRITE_NOW ||
				req_q.command == CMD_WRITE_DELAYED) begin
			one.result_buffer = req_q.buffer_index;
			if (idx_ok && held_q[idx] && (req_q.command == CMD_RELEASE || valid_q[idx]))
				do_app = 1'b1;
			if (idx_ok && valid_q[idx] && req_q.command == CMD_WRITE_NOW) begin
				one.disk_op = OP_WRITE;
				one.disk_block = BLK_W'(tag_q[idx]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q <= '0;
			dirty_q <= '0;
			held_q <= '0;
			fcount_q <= CW'(BUFFERS);
			for (int i = 0; i < BUFFERS; i++) order_q[i] <= BW'(i);
			scan_q <= '0;
		end else begin
			if (cmd.load) scan_q <= '0;
			if (cmd.evict) pend_q <= ev_r;
			if (cmd.execute) begin
				pend_q <= one;
				if (do_rm) begin
					for (int i = 0; i < BUFFERS - 1; i++)
						if (32'(i) >= 32'(pos)) order_q[i] <= order_q[i+1];
					fcount_q <= fcount_q - 1'b1;
					held_q[tgt] <= 1'b1;
					if (!found_q) begin
						dirty_q[tgt] <= 1'b0;
						tag_q[tgt] <= blk_q;
						valid_q[tgt] <= 1'b1;
						done_q[tgt] <= one.disk_op == OP_READ;
					end else if (one.disk_op == OP_READ) begin
						done_q[tgt] <= 1'b1;
					end
				end
				if (idx_ok && valid_q[idx] && (req_q.command == CMD_WRITE_NOW ||
						req_q.command == CMD_WRITE_DELAYED)) begin
					done_q[idx] <= 1'b1;
					dirty_q[idx] <= req_q.command == CMD_WRITE_DELAYED;
				end
				if (do_app) begin
					held_q[app] <= 1'b0;
					order_q[fcount_q[BW-1:0]] <= app;
					fcount_q <= fcount_q + 1'b1;
				end
			end
			if (cmd.scan) begin
				pend_q <= sc_r;
				if (dirty_q[scan_q]) begin
					dirty_q[scan_q] <= 1'b0;
					done_q[scan_q] <= 1'b1;
				end
				if (32'(scan_q) != BUFFERS - 1) scan_q <= scan_q + 1'b1;
			end
		end
	end

	// Request and lookup capture, and the result output register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			blk_q <= blk_in;
			found_q <= found_c;
			fbuf_q <= fbuf_c;
		end
		if (cmd.emit) rsp_q <= pend_q;
	end
endmodule

@@ design/lbc_ctrl.sv @@
// Command sequencer for the buffer cache.
module lbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  lbc_pkg::sts_t sts,
	output lbc_pkg::cmd_t cmd
);
	import lbc_pkg::*;
	`include "lru_block_buffer_cache_defines.svh"

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_FILL = 3'd5;

	logic [2:0] state_q, ret_q;
	logic full_q;
	logic done_q; // final result already queued

	logic free_out;
	assign free_out = !full_q || out_ready;
	assign out_valid = full_q;
	assign in_ready = state_q == S_IDLE;

	// Result path: pend_q loaded in DECIDE/EXEC/SCAN, moved into output in FILL.
	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		case (state_q)
			S_DECIDE: begin
				cmd.evict = sts.need_evict;
				cmd.execute = !sts.need_evict && !sts.is_flush;
				cmd.scan = sts.is_flush;
			end
			S_EXEC: cmd.execute = 1'b1;
			S_SCAN: cmd.scan = 1'b1;
			S_FILL: cmd.emit = free_out;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			full_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.emit) full_q <= 1'b1;
			else if (out_valid && out_ready) full_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_DECIDE;
				S_DECIDE: begin
					state_q <= S_FILL;
					if (sts.need_evict) begin
						ret_q <= S_EXEC;
						done_q <= 1'b0;
					end else if (sts.is_flush) begin
						ret_q <= S_SCAN;
						done_q <= !sts.more_dirty;
						if (!sts.scan_dirty && sts.more_dirty) state_q <= S_SCAN;
					end else begin
						ret_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_FILL;
					ret_q <= S_IDLE;
					done_q <= 1'b1;
				end
				S_SCAN: begin
					done_q <= !sts.more_dirty;
					if (sts.scan_dirty || !sts.more_dirty) state_q <= S_FILL;
				end
				S_FILL: if (free_out) begin
					state_q <= done_q ? S_IDLE : ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LBC_NEVER_BOTH(a_load_busy, clk, arst_n, cmd.load, state_q != S_IDLE, "load outside idle")
	`LBC_ASSERT(a_fill_sets, clk, arst_n, cmd.emit |=> full_q, "emitted result not shown")
	`LBC_NEVER_BOTH(a_one_op, clk, arst_n, cmd.evict, cmd.execute, "evict and execute together")
endmodule

@@ design/lru_block_buffer_cache.sv @@
// Buffer cache top level: LRU buffer table with delayed write.
// A request passes through DECIDE and FILL to its first result; a victim write-back
// adds EXEC and a second FILL. Requests are taken only in IDLE, after the previous
// request's last result is registered; a flush scans up to the last dirty buffer.
// Reset clears all buffer flags and puts every buffer in the free queue in index order.
module lru_block_buffer_cache #(
	parameter int BUFFERS = 16,
	parameter int BLOCK_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	lbc_stream_if.sink   req,
	lbc_stream_if.source rsp
);
	import lbc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lbc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	lbc_datapath #(.BUFFERS(BUFFERS), .BLOCK_BITS(BLOCK_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.req(req.data), .cmd(cmd), .sts(sts), .rsp(rsp.data)
	);
endmodule

@@ tb/sv/lbc_result_checker.sv @@
// Result checker: mirrors the buffer table and compares every result.
module lbc_result_checker (
	input  logic   clk,
	input  logic   arst_n,
	lbc_stream_if  req,
	lbc_stream_if  rsp,
	output int     errors,
	output int     pending,
	output int     checked
);
	import lbc_pkg::*;

	localparam int NBUF = 16;
	localparam int MAX_WRITES = 16;

	logic [BLK_W-1:0] tag [NBUF];
	bit               tag_valid [NBUF];
	bit               data_done [NBUF];
	bit               dirty [NBUF];
	bit               held [NBUF];
	int               free_lru [$];
	rsp_t             due_results [$];

	function automatic void emit(logic [STS_W-1:0] st, int b, bit h, logic [OP_W-1:0] op,
			logic [BLK_W-1:0] blk, bit lst);
		rsp_t r;
		r.status = st;
		r.result_buffer = b[IDX_W-1:0];
		r.hit = h;
		r.disk_op = op;
		r.disk_block = blk;
		r.last = lst;
		due_results.push_back(r);
	endfunction

	function automatic void give_back(int b);
		if (held[b]) begin
			held[b] = 0;
			free_lru.push_back(b);
		end
	endfunction

	function automatic void cache_apply(req_t r);
		int b;
		int n;
		bit found;
		found = 0;
		b = 0;
		n = 0;
		case (r.command)
			CMD_GET, CMD_READ: begin
				for (int i = 0; i < NBUF; i++)
					if (!found && tag_valid[i] && tag[i] == r.block_number) begin
						found = 1;
						b = i;
					end
				if (found && held[b]) begin
					emit(STS_BUSY, b, 1, OP_NONE, '0, 1);
					return;
				end
				if (found) begin
					foreach (free_lru[i])
						if (free_lru[i] == b) begin
							free_lru.delete(i);
							break;
						end
					held[b] = 1;
				end else begin
					if (free_lru.size() == 0) begin
						emit(STS_NO_FREE, 0, 0, OP_NONE, '0, 1);
						return;
					end
					b = free_lru.pop_front();
					held[b] = 1;
					// dirty victim goes back to disk before the new tag takes over
					if (tag_valid[b] && dirty[b])
						emit(STS_OK, b, 0, OP_WRITE, tag[b], 0);
					dirty[b] = 0;
					data_done[b] = 0;
					tag[b] = r.block_number;
					tag_valid[b] = 1;
				end
				if (r.command == CMD_READ && !data_done[b] && !dirty[b]) begin
					data_done[b] = 1;
					emit(STS_OK, b, found, OP_READ, r.block_number, 1);
				end else
					emit(STS_OK, b, found, OP_NONE, '0, 1);
			end
			CMD_RELEASE: begin
				give_back(int'(r.buffer_index));
				emit(STS_OK, int'(r.buffer_index), 0, OP_NONE, '0, 1);
			end
			CMD_WRITE_NOW, CMD_WRITE_DELAYED: begin
				b = int'(r.buffer_index);
				if (!tag_valid[b]) begin
					emit(STS_OK, b, 0, OP_NONE, '0, 1);
					return;
				end
				data_done[b] = 1;
				dirty[b] = (r.command == CMD_WRITE_DELAYED);
				give_back(b);
				if (r.command == CMD_WRITE_NOW)
					emit(STS_OK, b, 0, OP_WRITE, tag[b], 1);
				else
					emit(STS_OK, b, 0, OP_NONE, '0, 1);
			end
			CMD_FLUSH: begin
				for (int i = 0; i < NBUF && n < MAX_WRITES; i++)
					if (dirty[i]) begin
						dirty[i] = 0;
						data_done[i] = 1;
						emit(STS_OK, i, 0, OP_WRITE, tag[i], 0);
						n++;
					end
				if (n == 0)
					emit(STS_OK, 0, 0, OP_NONE, '0, 1);
				else
					due_results[$].last = 1;
			end
			default: emit(STS_OK, 0, 0, OP_NONE, '0, 1);
		endcase
	endfunction

	initial begin
		errors = 0;
		checked = 0;
		pending = 0;
		for (int i = 0; i < NBUF; i++) begin
			tag[i] = '0;
			tag_valid[i] = 0;
			data_done[i] = 0;
			dirty[i] = 0;
			held[i] = 0;
			free_lru.push_back(i);
		end
	end

	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		if (arst_n && req.valid && req.ready)
			cache_apply(req.data);
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			checked++;
			if (due_results.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.result_buffer !== want.result_buffer) begin
					$error("result_buffer: expected %0d, got %0d",
						want.result_buffer, got.result_buffer);
					errors++;
				end
				if (got.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, got.hit);
					errors++;
				end
				if (got.disk_op !== want.disk_op) begin
					$error("disk_op: expected %0d, got %0d", want.disk_op, got.disk_op);
					errors++;
				end
				if (got.disk_block !== want.disk_block) begin
					$error("disk_block: expected %h, got %h", want.disk_block, got.disk_block);
					errors++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, got.last);
					errors++;
				end
			end
		end
		pending = due_results.size();
	end
endmodule

@@ tb/sv/tb.sv @@
// Testbench top: request stimulus, result back-pressure and verdict.
module tb;
	import lbc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;
	localparam int CYCLE_LIMIT = 300000;

	logic clk;
	logic arst_n;
	int   errors, pending, checked;
	int   sent;
	int   cycles;
	bit   hold_off;
	bit   fast;

	lbc_stream_if #(.T(req_t)) req_ch ();
	lbc_stream_if #(.T(rsp_t)) rsp_ch ();

	lru_block_buffer_cache DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	lbc_result_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: random stall per result, plus the long hold-off on request.
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = fast ? 0 : $urandom_range(0, 18);
			rsp_ch.ready = 1'b0;
			repeat (gap) @(negedge clk);
			while (hold_off) @(negedge clk);
			rsp_ch.ready = 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	task automatic send_request(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk,
			logic [IDX_W-1:0] idx);
		int gap;
		gap = fast ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data = '{command: cmd, block_number: blk, buffer_index: idx};
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic random_request();
		int pick;
		logic [BLK_W-1:0] blk;
		pick = $urandom_range(0, 99);
		// mostly a small pool of blocks so hits, busy and evictions happen
		blk = ($urandom_range(0, 9) == 0) ? BLK_W'($urandom) : BLK_W'($urandom_range(0, 23));
		if (pick < 40)
			send_request(pick < 20 ? CMD_GET : CMD_READ, blk, 4'($urandom));
		else if (pick < 65)
			send_request(CMD_RELEASE, blk, 4'($urandom));
		else if (pick < 80)
			send_request(CMD_WRITE_DELAYED, blk, 4'($urandom));
		else if (pick < 90)
			send_request(CMD_WRITE_NOW, blk, 4'($urandom));
		else if (pick < 96)
			send_request(CMD_FLUSH, blk, 4'($urandom));
		else
			send_request(pick < 98 ? CMD_RSVD_A : CMD_RSVD_B, blk, 4'($urandom));
	endtask

	initial begin
		cycles = 0;
		sent = 0;
		hold_off = 0;
		fast = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, busy hit, write paths, ignored commands
		send_request(CMD_READ, 24'h000000, 4'd0);
		send_request(CMD_READ, 24'hFFFFFF, 4'd15);
		send_request(CMD_GET, 24'hFFFFFF, 4'd0);
		send_request(CMD_RELEASE, 24'h0, 4'd1);
		send_request(CMD_READ, 24'hFFFFFF, 4'd0);
		send_request(CMD_WRITE_NOW, 24'h0, 4'd1);
		send_request(CMD_WRITE_DELAYED, 24'h0, 4'd0);
		send_request(CMD_RELEASE, 24'h0, 4'd15);
		send_request(CMD_WRITE_NOW, 24'h0, 4'd15);
		send_request(CMD_FLUSH, 24'h0, 4'd0);
		send_request(CMD_FLUSH, 24'h0, 4'd0);
		send_request(CMD_RSVD_A, 24'hABCDEF, 4'd9);
		send_request(CMD_RSVD_B, 24'h123456, 4'd6);

		// fill every buffer, then miss with nothing free
		fast = 1;
		for (int i = 0; i < 16; i++)
			send_request(CMD_GET, BLK_W'(24'h100 + i), 4'd0);
		send_request(CMD_READ, 24'h5A5A5A, 4'd0);
		// dirty all, flush them in one command, dirty again so a miss evicts dirty
		for (int i = 0; i < 16; i++)
			send_request(CMD_WRITE_DELAYED, 24'h0, 4'(i));
		send_request(CMD_FLUSH, 24'h0, 4'd0);
		for (int i = 0; i < 4; i++)
			send_request(CMD_WRITE_DELAYED, 24'h0, 4'(i));
		send_request(CMD_READ, 24'hC0FFEE, 4'd0);
		fast = 0;

		// sender waits for every result before the random part
		wait (pending == 0);
		@(negedge clk);

		for (int i = 0; i < 110; i++) begin
			if (i == 40) begin
				fast = 1;
				hold_off = 1;
			end
			if (i == 60)
				fast = 0;
			if (i == 95)
				fast = 1;
			if (i == 105)
				fast = 0;
			if (i == 90) begin
				wait (pending == 0);
				@(negedge clk);
			end
			random_request();
		end

		wait (pending == 0);
		repeat (40) @(posedge clk);
		$display("tb: %0d requests sent, %0d results checked", sent, checked);
		$display("tb: covered hits, busy, no-free, dirty eviction, flush and ignored commands");
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// long receiver hold-off counted in its own process
	always @(posedge hold_off) begin
		repeat (300) @(posedge clk);
		hold_off = 0;
	end
endmodule
